@@ rtl/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types, type codes and helpers for the numeric type converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam logic [2:0] TY_I8  = 3'd0;
  localparam logic [2:0] TY_I16 = 3'd1;
  localparam logic [2:0] TY_I32 = 3'd2;
  localparam logic [2:0] TY_I64 = 3'd3;
  localparam logic [2:0] TY_F32 = 3'd4;
  localparam logic [2:0] TY_F64 = 3'd5;
  localparam logic [2:0] TY_U64 = 3'd6;

  localparam logic CFG_SOURCE_TYPE = 1'b0;
  localparam logic CFG_DEST_TYPE   = 1'b1;

  typedef enum logic [2:0] {
    OP_INT,
    OP_COPY,
    OP_I2F,
    OP_F2I,
    OP_S2D,
    OP_D2S,
    OP_ERR
  } op_t;

  typedef logic signed [12:0] exp_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] dt;
    logic       sign;
    logic       nan;
    logic       inf;
    logic       zero;
    logic       sub;
    logic       last;
  } meta_t;

  function automatic logic [63:0] width_mask(input logic [2:0] ty);
    logic [63:0] m;
    case (ty)
      TY_I8:          m = 64'h0000_0000_0000_00FF;
      TY_I16:         m = 64'h0000_0000_0000_FFFF;
      TY_I32, TY_F32: m = 64'h0000_0000_FFFF_FFFF;
      default:        m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/numeric_type_converter_core.sv @@
// ----------------------------------------------------------------------------
// numeric_type_converter_core
// Converts one array element per transaction between integer and float types.
// ----------------------------------------------------------------------------
// Usage:
//   Program source and destination type through cfg_we / cfg_index /
//   cfg_wdata while no transaction is in flight. Index 0 is the source type,
//   index 1 the destination type.
//   Present an element on in_source_bits / in_last_element with start high;
//   it is taken at any clock edge where start is high and busy is low. busy
//   stays low, so one element can enter every cycle.
//   The result appears on out_dest_bits, out_range_flag, out_pair_error and
//   out_last_result for one cycle, marked by out_valid. Throughput is one
//   element per cycle; the five pipeline stages are decode, leading-zero
//   count, normalize, align and round/pack.
//   The receiver takes every result in the cycle it is shown.
//   Reset clears both type registers to 0 and empties the pipeline.
// ----------------------------------------------------------------------------
module numeric_type_converter_core import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_source_bits,
  input  logic        in_last_element,
  output logic        out_valid,
  output logic [63:0] out_dest_bits,
  output logic        out_range_flag,
  output logic        out_pair_error,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  logic [2:0]  source_type_r, dest_type_r;
  logic        d_valid, n_valid, a_valid;
  meta_t       d_meta, n_meta, a_meta;
  exp_t        d_ue, n_ue, a_ue;
  logic [63:0] d_sig, n_sig, a_q;
  logic [6:0]  n_rsh;
  logic        a_rnd, a_stk;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_type_r <= TY_I8;
      dest_type_r   <= TY_I8;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SOURCE_TYPE) source_type_r <= cfg_wdata;
      if (cfg_index == CFG_DEST_TYPE) dest_type_r <= cfg_wdata;
    end
  end

  ntc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .src_type  (source_type_r),
    .dst_type  (dest_type_r),
    .src_bits  (in_source_bits),
    .src_last  (in_last_element),
    .out_valid (d_valid),
    .out_meta  (d_meta),
    .out_ue    (d_ue),
    .out_sig   (d_sig)
  );

  ntc_normalize u_normalize (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_meta   (d_meta),
    .in_ue     (d_ue),
    .in_sig    (d_sig),
    .out_valid (n_valid),
    .out_meta  (n_meta),
    .out_ue    (n_ue),
    .out_sig   (n_sig),
    .out_rsh   (n_rsh)
  );

  ntc_align u_align (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_valid),
    .in_meta   (n_meta),
    .in_ue     (n_ue),
    .in_sig    (n_sig),
    .in_rsh    (n_rsh),
    .out_valid (a_valid),
    .out_meta  (a_meta),
    .out_ue    (a_ue),
    .out_q     (a_q),
    .out_rnd   (a_rnd),
    .out_stk   (a_stk)
  );

  ntc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_meta   (a_meta),
    .in_ue     (a_ue),
    .in_q      (a_q),
    .in_rnd    (a_rnd),
    .in_stk    (a_stk),
    .out_valid (out_valid),
    .out_bits  (out_dest_bits),
    .out_range (out_range_flag),
    .out_err   (out_pair_error),
    .out_last  (out_last_result)
  );

endmodule

@@ rtl/ntc_decode.sv @@
// ----------------------------------------------------------------------------
// ntc_decode
// Stage 1: select the operation and unpack the source into sign, exponent
// and significand (left-aligned for float sources).
// ----------------------------------------------------------------------------
module ntc_decode import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [2:0]  src_type,
  input  logic [2:0]  dst_type,
  input  logic [63:0] src_bits,
  input  logic        src_last,
  output logic        out_valid,
  output meta_t       out_meta,
  output exp_t        out_ue,
  output logic [63:0] out_sig
);

  logic        valid_r;
  meta_t       meta_r, meta_nxt;
  exp_t        ue_r, ue_nxt;
  logic [63:0] sig_r, sig_nxt;
  logic [63:0] ival, mag;
  logic [7:0]  e8;
  logic [10:0] e11;

  always_comb begin
    case (src_type)
      TY_I8:   ival = {{56{src_bits[7]}}, src_bits[7:0]};
      TY_I16:  ival = {{48{src_bits[15]}}, src_bits[15:0]};
      TY_I32:  ival = {{32{src_bits[31]}}, src_bits[31:0]};
      default: ival = src_bits;
    endcase
    mag = ival[63] ? (~ival + 64'd1) : ival;
    e8  = src_bits[30:23];
    e11 = src_bits[62:52];

    meta_nxt      = '0;
    meta_nxt.dt   = dst_type;
    meta_nxt.last = src_last;
    meta_nxt.op   = OP_ERR;
    if (dst_type == TY_U64) begin
      if (src_type == TY_F64) meta_nxt.op = OP_F2I;
    end else if (dst_type <= TY_F64 && src_type <= TY_F64) begin
      if (src_type <= TY_I64) meta_nxt.op = (dst_type <= TY_I64) ? OP_INT : OP_I2F;
      else if (dst_type <= TY_I64) meta_nxt.op = OP_F2I;
      else if (dst_type == src_type) meta_nxt.op = OP_COPY;
      else if (src_type == TY_F32) meta_nxt.op = OP_S2D;
      else meta_nxt.op = OP_D2S;
    end

    ue_nxt  = 13'sd63;
    sig_nxt = src_bits;
    if (meta_nxt.op == OP_INT) begin
      sig_nxt = ival;
    end else if (meta_nxt.op == OP_COPY) begin
      sig_nxt = src_bits;
    end else if (src_type <= TY_I64) begin
      meta_nxt.sign = ival[63];
      meta_nxt.zero = (mag == 64'd0);
      sig_nxt       = mag;
    end else if (src_type == TY_F32) begin
      meta_nxt.sign = src_bits[31];
      meta_nxt.nan  = (e8 == 8'hFF) && (src_bits[22:0] != 23'd0);
      meta_nxt.inf  = (e8 == 8'hFF) && (src_bits[22:0] == 23'd0);
      meta_nxt.sub  = (e8 == 8'd0);
      meta_nxt.zero = (e8 == 8'd0) && (src_bits[22:0] == 23'd0);
      ue_nxt  = (e8 == 8'd0) ? -13'sd126 : $signed({5'd0, e8}) - 13'sd127;
      sig_nxt = {(e8 != 8'd0), src_bits[22:0], 40'd0};
    end else begin
      meta_nxt.sign = src_bits[63];
      meta_nxt.nan  = (e11 == 11'h7FF) && (src_bits[51:0] != 52'd0);
      meta_nxt.inf  = (e11 == 11'h7FF) && (src_bits[51:0] == 52'd0);
      meta_nxt.sub  = (e11 == 11'd0);
      meta_nxt.zero = (e11 == 11'd0) && (src_bits[51:0] == 52'd0);
      ue_nxt  = (e11 == 11'd0) ? -13'sd1022 : $signed({2'd0, e11}) - 13'sd1023;
      sig_nxt = {(e11 != 11'd0), src_bits[51:0], 11'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
    meta_r <= meta_nxt;
    ue_r   <= ue_nxt;
    sig_r  <= sig_nxt;
  end

  assign out_valid = valid_r;
  assign out_meta  = meta_r;
  assign out_ue    = ue_r;
  assign out_sig   = sig_r;

endmodule

@@ rtl/ntc_normalize.sv @@
// ----------------------------------------------------------------------------
// ntc_normalize
// Stages 2 and 3: count leading zeros, then shift the significand up,
// adjust the exponent and work out the right-shift for alignment.
// ----------------------------------------------------------------------------
module ntc_normalize import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  meta_t       in_meta,
  input  exp_t        in_ue,
  input  logic [63:0] in_sig,
  output logic        out_valid,
  output meta_t       out_meta,
  output exp_t        out_ue,
  output logic [63:0] out_sig,
  output logic [6:0]  out_rsh
);

  logic        v2_r, v3_r;
  meta_t       m2_r, m3_r;
  exp_t        ue2_r, ue3_r, ue_nxt, dsub;
  logic [63:0] sig2_r, sig3_r, sig_nxt;
  logic [6:0]  lz_r, lz_nxt, rsh_r, rsh_nxt;
  logic        norm_en;

  always_comb begin
    lz_nxt = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (in_sig[i]) lz_nxt = 7'(63 - i);
    end
  end

  always_comb begin
    norm_en = (m2_r.op != OP_INT) && (m2_r.op != OP_COPY);
    sig_nxt = norm_en ? (sig2_r << lz_r) : sig2_r;
    ue_nxt  = norm_en ? (ue2_r - $signed({6'd0, lz_r})) : ue2_r;
    dsub    = -13'sd86 - ue_nxt;
    rsh_nxt = 7'd0;
    if (!m2_r.nan && !m2_r.inf) begin
      case (m2_r.op)
        OP_I2F: rsh_nxt = (m2_r.dt == TY_F32) ? 7'd40 : 7'd11;
        OP_D2S: begin
          if (ue_nxt >= -13'sd126) rsh_nxt = 7'd40;
          else if (dsub > 13'sd127) rsh_nxt = 7'd127;
          else rsh_nxt = dsub[6:0];
        end
        OP_F2I: begin
          if (ue_nxt >= 13'sd0 && ue_nxt <= 13'sd63) rsh_nxt = 7'd63 - ue_nxt[6:0];
        end
        default: rsh_nxt = 7'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= in_valid;
      v3_r <= v2_r;
    end
    m2_r   <= in_meta;
    ue2_r  <= in_ue;
    sig2_r <= in_sig;
    lz_r   <= lz_nxt;
    m3_r   <= m2_r;
    ue3_r  <= ue_nxt;
    sig3_r <= sig_nxt;
    rsh_r  <= rsh_nxt;
  end

  assign out_valid = v3_r;
  assign out_meta  = m3_r;
  assign out_ue    = ue3_r;
  assign out_sig   = sig3_r;
  assign out_rsh   = rsh_r;

endmodule

@@ rtl/ntc_align.sv @@
// ----------------------------------------------------------------------------
// ntc_align
// Stage 4: right-shift the significand, keeping round and sticky bits.
// ----------------------------------------------------------------------------
module ntc_align import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  meta_t       in_meta,
  input  exp_t        in_ue,
  input  logic [63:0] in_sig,
  input  logic [6:0]  in_rsh,
  output logic        out_valid,
  output meta_t       out_meta,
  output exp_t        out_ue,
  output logic [63:0] out_q,
  output logic        out_rnd,
  output logic        out_stk
);

  logic         valid_r, rnd_r, stk_r;
  meta_t        meta_r;
  exp_t         ue_r;
  logic [63:0]  q_r;
  logic [127:0] wide;

  assign wide = {in_sig, 64'd0} >> in_rsh;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
    meta_r <= in_meta;
    ue_r   <= in_ue;
    q_r    <= wide[127:64];
    rnd_r  <= wide[63];
    stk_r  <= |wide[62:0];
  end

  assign out_valid = valid_r;
  assign out_meta  = meta_r;
  assign out_ue    = ue_r;
  assign out_q     = q_r;
  assign out_rnd   = rnd_r;
  assign out_stk   = stk_r;

endmodule

@@ rtl/ntc_pack.sv @@
// ----------------------------------------------------------------------------
// ntc_pack
// Stage 5: round, saturate and pack the destination bits and flags.
// ----------------------------------------------------------------------------
module ntc_pack import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  meta_t       in_meta,
  input  exp_t        in_ue,
  input  logic [63:0] in_q,
  input  logic        in_rnd,
  input  logic        in_stk,
  output logic        out_valid,
  output logic [63:0] out_bits,
  output logic        out_range,
  output logic        out_err,
  output logic        out_last
);

  logic        valid_r, range_r, err_r, last_r;
  logic [63:0] bits_r;
  logic [63:0] m, mag, v, lim;
  logic        flag, err, hi_nz, over;
  logic [12:0] e_sum;

  always_comb begin
    m     = in_q + {63'd0, in_rnd & (in_stk | in_q[0])};
    v     = 64'd0;
    flag  = 1'b0;
    err   = 1'b0;
    e_sum = 13'd0;
    mag   = 64'd0;
    hi_nz = 1'b0;
    lim   = 64'h8000_0000_0000_0000;
    over  = 1'b0;
    case (in_meta.op)
      OP_INT, OP_COPY: v = in_q;
      OP_I2F: begin
        if (in_meta.zero) begin
          v = 64'd0;
        end else if (in_meta.dt == TY_F32) begin
          e_sum = in_ue + 13'sd127 + $signed({12'd0, m[24]});
          v = {32'd0, in_meta.sign, e_sum[7:0], m[22:0]};
        end else begin
          e_sum = in_ue + 13'sd1023 + $signed({12'd0, m[53]});
          v = {in_meta.sign, e_sum[10:0], m[51:0]};
        end
      end
      OP_S2D: begin
        e_sum = in_ue + 13'sd1023;
        if (in_meta.nan) v = {in_meta.sign, 11'h7FF, 1'b1, in_q[61:40], 29'd0};
        else if (in_meta.inf) v = {in_meta.sign, 11'h7FF, 52'd0};
        else if (in_meta.zero) v = {in_meta.sign, 63'd0};
        else v = {in_meta.sign, e_sum[10:0], in_q[62:11]};
      end
      OP_D2S: begin
        e_sum = in_ue + 13'sd127 + $signed({12'd0, m[24]});
        if (in_meta.nan) v = {32'd0, in_meta.sign, 8'hFF, 1'b1, in_q[61:40]};
        else if (in_meta.inf || in_ue > 13'sd127) v = {32'd0, in_meta.sign, 8'hFF, 23'd0};
        else if (in_meta.sub) v = {32'd0, in_meta.sign, 31'd0};
        else if (in_ue >= -13'sd126) v = {32'd0, in_meta.sign, e_sum[7:0], m[22:0]};
        else v = {32'd0, in_meta.sign, m[30:0]};
      end
      OP_F2I: begin
        mag = (in_meta.sub || in_ue < 13'sd0) ? 64'd0 : in_q;
        case (in_meta.dt)
          TY_I8:   begin hi_nz = |mag[63:7];  lim = 64'h80; end
          TY_I16:  begin hi_nz = |mag[63:15]; lim = 64'h8000; end
          TY_I32:  begin hi_nz = |mag[63:31]; lim = 64'h8000_0000; end
          default: begin hi_nz = mag[63];     lim = 64'h8000_0000_0000_0000; end
        endcase
        if (in_meta.nan) begin
          flag = 1'b1;
          v    = 64'd0;
        end else begin
          if (in_meta.inf || (!in_meta.sub && in_ue >= 13'sd64)) over = 1'b1;
          else if (in_meta.dt == TY_U64) over = in_meta.sign && (mag != 64'd0);
          else if (in_meta.sign) over = hi_nz && (mag != lim);
          else over = hi_nz;
          if (over) begin
            flag = 1'b1;
            if (in_meta.dt == TY_U64) v = in_meta.sign ? 64'd0 : '1;
            else v = in_meta.sign ? lim : (lim - 64'd1);
          end else if (in_meta.dt == TY_U64) begin
            v = mag;
          end else begin
            v = in_meta.sign ? (~mag + 64'd1) : mag;
          end
        end
      end
      default: err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
    bits_r  <= err ? 64'd0 : (v & width_mask(in_meta.dt));
    range_r <= flag;
    err_r   <= err;
    last_r  <= in_meta.last;
  end

  assign out_valid = valid_r;
  assign out_bits  = bits_r;
  assign out_range = range_r;
  assign out_err   = err_r;
  assign out_last  = last_r;

endmodule
